FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; clock and reset are passed by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ddo_pkg.sv
// Shared types, constants and tables of the odometry integrator.
// No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  localparam logic [34:0] DIST_K      = 35'd1125899907;
  localparam logic [34:0] HEAD_K      = 35'd11468322278;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_SPEED_OFFSET  = 3'd0;
  localparam logic [2:0] REG_VELOCITY_GAIN = 3'd1;
  localparam logic [2:0] REG_WHEEL_DB      = 3'd2;
  localparam logic [2:0] REG_INV_TRACK     = 3'd3;
  localparam logic [2:0] REG_TURN_DB       = 3'd4;

  typedef struct packed {
    logic signed [15:0] right_speed;
    logic signed [15:0] left_speed;
    logic        [31:0] stamp_us;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] forward_rate;
    logic signed [31:0] turn_rate;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_LO, OP_MUL_HI, OP_WHEEL_R, OP_WHEEL_L, OP_SUMS,
    OP_TURN, OP_PROD, OP_DIST, OP_CORDIC_INIT, OP_CORDIC_STEP, OP_CORDIC_FIN,
    OP_POS_X, OP_POS_Y, OP_HEAD, OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_WR, MS_WL, MS_TURN, MS_FD, MS_DK, MS_X, MS_Y, MS_HD, MS_HK
  } mul_sel_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RM0, ST_RM1, ST_RF, ST_LM0, ST_LM1, ST_LF, ST_SUMS,
    ST_TM0, ST_TM1, ST_TF, ST_FD0, ST_FD1, ST_FDF, ST_DK0, ST_DK1, ST_DKF,
    ST_CI, ST_CS, ST_CF, ST_XM0, ST_XM1, ST_XF, ST_YM0, ST_YM1, ST_YF,
    ST_HD0, ST_HD1, ST_HDF, ST_HK0, ST_HK1, ST_HKF, ST_QI, ST_QS, ST_QF,
    ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t             op;
    mul_sel_t           msel;
    logic               chalf;
    logic [STEP_W-1:0]  step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/diff_drive_odometry_integrator_core.sv
// Top level of the differential-drive odometry integrator.
// Depends on ddo_pkg, ddo_ctrl and ddo_dp.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one word per motor
//   report: right and left speed plus a microsecond stamp. Result channel
//   out_valid/out_stall/out_data returns one word per report: pose x/y,
//   heading, quaternion z/w, forward and turn rate.
//   cfg_we/cfg_addr/cfg_wdata write the five tuning registers; write only
//   while no report is in flight. Unknown indexes are dropped.
// Timing:
//   A report is taken only while the core is idle. From acceptance the
//   sequencer walks it through all of its states and then registers the
//   result; the next report can be taken only after that, so one report
//   is in flight at a time. The two CORDIC passes (old heading, then half
//   of the new heading) on one shared rotator, and nine two-pass products
//   on one 33x35 multiplier make up that sequence.
// Reset and stall:
//   Reset restores the register defaults, zeroes pose, heading and stamp
//   history (the first report then sees zero elapsed time) and drops any
//   pending result. A stalled result holds in the output register; the
//   core finishes its current report and waits there until the word goes.
module diff_drive_odometry_integrator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  ddo_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ddo_pkg::out_word_t out_data
);

  ddo_pkg::dp_cmd_t    cmd;     // sequencer -> datapath
  ddo_pkg::dp_status_t status;  // datapath -> sequencer

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ddo_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: rtl/ddo_ctrl.sv
// Sequencer of the odometry integrator: walks one report through the datapath.
// Depends on ddo_pkg.
module ddo_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddo_pkg::dp_status_t status,
  output ddo_pkg::dp_cmd_t    cmd
);

  ddo_pkg::state_t state_r, state_nxt;
  logic [ddo_pkg::STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddo_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != ddo_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ddo_pkg::ST_IDLE: if (in_valid) state_nxt = ddo_pkg::ST_RM0;
      ddo_pkg::ST_RM0:  state_nxt = ddo_pkg::ST_RM1;
      ddo_pkg::ST_RM1:  state_nxt = ddo_pkg::ST_RF;
      ddo_pkg::ST_RF:   state_nxt = ddo_pkg::ST_LM0;
      ddo_pkg::ST_LM0:  state_nxt = ddo_pkg::ST_LM1;
      ddo_pkg::ST_LM1:  state_nxt = ddo_pkg::ST_LF;
      ddo_pkg::ST_LF:   state_nxt = ddo_pkg::ST_SUMS;
      ddo_pkg::ST_SUMS: state_nxt = ddo_pkg::ST_TM0;
      ddo_pkg::ST_TM0:  state_nxt = ddo_pkg::ST_TM1;
      ddo_pkg::ST_TM1:  state_nxt = ddo_pkg::ST_TF;
      ddo_pkg::ST_TF:   state_nxt = ddo_pkg::ST_FD0;
      ddo_pkg::ST_FD0:  state_nxt = ddo_pkg::ST_FD1;
      ddo_pkg::ST_FD1:  state_nxt = ddo_pkg::ST_FDF;
      ddo_pkg::ST_FDF:  state_nxt = ddo_pkg::ST_DK0;
      ddo_pkg::ST_DK0:  state_nxt = ddo_pkg::ST_DK1;
      ddo_pkg::ST_DK1:  state_nxt = ddo_pkg::ST_DKF;
      ddo_pkg::ST_DKF:  state_nxt = ddo_pkg::ST_CI;
      ddo_pkg::ST_CI: begin
        state_nxt = ddo_pkg::ST_CS;
        step_nxt  = '0;
      end
      ddo_pkg::ST_CS: begin
        if (step_r == ddo_pkg::STEP_LAST) begin
          state_nxt = ddo_pkg::ST_CF;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ddo_pkg::ST_CF:   state_nxt = ddo_pkg::ST_XM0;
      ddo_pkg::ST_XM0:  state_nxt = ddo_pkg::ST_XM1;
      ddo_pkg::ST_XM1:  state_nxt = ddo_pkg::ST_XF;
      ddo_pkg::ST_XF:   state_nxt = ddo_pkg::ST_YM0;
      ddo_pkg::ST_YM0:  state_nxt = ddo_pkg::ST_YM1;
      ddo_pkg::ST_YM1:  state_nxt = ddo_pkg::ST_YF;
      ddo_pkg::ST_YF:   state_nxt = ddo_pkg::ST_HD0;
      ddo_pkg::ST_HD0:  state_nxt = ddo_pkg::ST_HD1;
      ddo_pkg::ST_HD1:  state_nxt = ddo_pkg::ST_HDF;
      ddo_pkg::ST_HDF:  state_nxt = ddo_pkg::ST_HK0;
      ddo_pkg::ST_HK0:  state_nxt = ddo_pkg::ST_HK1;
      ddo_pkg::ST_HK1:  state_nxt = ddo_pkg::ST_HKF;
      ddo_pkg::ST_HKF:  state_nxt = ddo_pkg::ST_QI;
      ddo_pkg::ST_QI: begin
        state_nxt = ddo_pkg::ST_QS;
        step_nxt  = '0;
      end
      ddo_pkg::ST_QS: begin
        if (step_r == ddo_pkg::STEP_LAST) begin
          state_nxt = ddo_pkg::ST_QF;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ddo_pkg::ST_QF:   state_nxt = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE: if (status.out_free) state_nxt = ddo_pkg::ST_IDLE;
      default:          state_nxt = ddo_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd       = '0;
    cmd.op    = ddo_pkg::OP_NONE;
    cmd.msel  = ddo_pkg::MS_NONE;
    cmd.step  = step_r;
    unique case (state_r)
      ddo_pkg::ST_IDLE: if (in_valid) cmd.op = ddo_pkg::OP_LOAD;
      ddo_pkg::ST_RM0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_WR; end
      ddo_pkg::ST_RM1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_WR; end
      ddo_pkg::ST_RF:  cmd.op = ddo_pkg::OP_WHEEL_R;
      ddo_pkg::ST_LM0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_WL; end
      ddo_pkg::ST_LM1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_WL; end
      ddo_pkg::ST_LF:  cmd.op = ddo_pkg::OP_WHEEL_L;
      ddo_pkg::ST_SUMS: cmd.op = ddo_pkg::OP_SUMS;
      ddo_pkg::ST_TM0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_TURN; end
      ddo_pkg::ST_TM1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_TURN; end
      ddo_pkg::ST_TF:  cmd.op = ddo_pkg::OP_TURN;
      ddo_pkg::ST_FD0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_FD; end
      ddo_pkg::ST_FD1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_FD; end
      ddo_pkg::ST_FDF: cmd.op = ddo_pkg::OP_PROD;
      ddo_pkg::ST_DK0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_DK; end
      ddo_pkg::ST_DK1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_DK; end
      ddo_pkg::ST_DKF: cmd.op = ddo_pkg::OP_DIST;
      ddo_pkg::ST_CI:  cmd.op = ddo_pkg::OP_CORDIC_INIT;
      ddo_pkg::ST_CS:  cmd.op = ddo_pkg::OP_CORDIC_STEP;
      ddo_pkg::ST_CF:  cmd.op = ddo_pkg::OP_CORDIC_FIN;
      ddo_pkg::ST_XM0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_X; end
      ddo_pkg::ST_XM1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_X; end
      ddo_pkg::ST_XF:  cmd.op = ddo_pkg::OP_POS_X;
      ddo_pkg::ST_YM0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_Y; end
      ddo_pkg::ST_YM1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_Y; end
      ddo_pkg::ST_YF:  cmd.op = ddo_pkg::OP_POS_Y;
      ddo_pkg::ST_HD0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_HD; end
      ddo_pkg::ST_HD1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_HD; end
      ddo_pkg::ST_HDF: cmd.op = ddo_pkg::OP_PROD;
      ddo_pkg::ST_HK0: begin cmd.op = ddo_pkg::OP_MUL_LO; cmd.msel = ddo_pkg::MS_HK; end
      ddo_pkg::ST_HK1: begin cmd.op = ddo_pkg::OP_MUL_HI; cmd.msel = ddo_pkg::MS_HK; end
      ddo_pkg::ST_HKF: cmd.op = ddo_pkg::OP_HEAD;
      ddo_pkg::ST_QI:  begin cmd.op = ddo_pkg::OP_CORDIC_INIT; cmd.chalf = 1'b1; end
      ddo_pkg::ST_QS:  cmd.op = ddo_pkg::OP_CORDIC_STEP;
      ddo_pkg::ST_QF:  cmd.op = ddo_pkg::OP_CORDIC_FIN;
      ddo_pkg::ST_DONE: if (status.out_free) cmd.op = ddo_pkg::OP_EMIT;
      default: cmd.op = ddo_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: rtl/ddo_dp.sv
// Datapath of the odometry integrator: config registers, shared multiplier,
// CORDIC rotator, pose accumulators and output register. Depends on ddo_pkg.
module ddo_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [23:0]         cfg_wdata,
  input  ddo_pkg::in_word_t   in_data,
  output ddo_pkg::out_word_t  out_data,
  output logic                out_valid,
  input  logic                out_stall,
  input  ddo_pkg::dp_cmd_t    cmd,
  output ddo_pkg::dp_status_t status
);

  // config
  logic [15:0] off_r, gain_r, wdb_r;
  logic [23:0] itw_r;
  logic [19:0] tdb_r;

  // per-report working registers
  ddo_pkg::in_word_t  in_r;
  logic signed [31:0] vr_r, vl_r, fwd_r, turn_r;
  logic signed [32:0] dif_r;
  logic        [31:0] dt_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] dist_r;
  logic signed [99:0] acc_r;
  logic signed [33:0] cx_r, cy_r, cz_r, c_r, s_r;
  logic               flip_r;

  // persistent state
  logic signed [47:0] acc_x_r, acc_y_r;
  logic        [31:0] acc_h_r, prev_r;
  logic               seen_r;

  ddo_pkg::out_word_t out_r;
  logic               out_valid_r;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [31:0] dband(input logic signed [31:0] v,
                                               input logic [19:0] th);
    logic [32:0] m;
    m = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    return (m < {13'b0, th}) ? 32'sd0 : v;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > $signed({3'b000, {47{1'b1}}}))      return {1'b0, {47{1'b1}}};
    else if (v < $signed({3'b111, {47{1'b0}}})) return {1'b1, {47{1'b0}}};
    else                                        return v[47:0];
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = ($signed({v[33], v}) + 35'sd16384) >>> 15;
    if (t > 35'sd32767)       return 16'sh7fff;
    else if (t < -35'sd32768) return 16'sh8000;
    else                      return t[15:0];
  endfunction

  // motor term: speed*256 plus offset toward its sign (zero counts negative)
  function automatic logic signed [25:0] motor(input logic signed [15:0] sp,
                                               input logic [15:0] off);
    logic signed [25:0] b;
    b = {{2{sp[15]}}, sp, 8'b0};
    return (sp > 16'sd0) ? b + $signed({10'b0, off}) : b - $signed({10'b0, off});
  endfunction

  // shared multiplier operands: A up to 65 bits in two passes, B 35 bits
  logic signed [64:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [25:0] m_sel;

  always_comb begin
    m_sel = motor(in_r.right_speed, off_r);
    mul_a = '0;
    mul_b = '0;
    case (cmd.msel)
      ddo_pkg::MS_WR: begin
        mul_a = {{39{m_sel[25]}}, m_sel};
        mul_b = {19'b0, gain_r};
      end
      ddo_pkg::MS_WL: begin
        m_sel = motor(in_r.left_speed, off_r);
        mul_a = {{39{m_sel[25]}}, m_sel};
        mul_b = {19'b0, gain_r};
      end
      ddo_pkg::MS_TURN: begin
        mul_a = {{32{dif_r[32]}}, dif_r};
        mul_b = {11'b0, itw_r};
      end
      ddo_pkg::MS_FD: begin
        mul_a = {{33{fwd_r[31]}}, fwd_r};
        mul_b = {3'b0, dt_r};
      end
      ddo_pkg::MS_DK: begin
        mul_a = {prod_r[63], prod_r};
        mul_b = ddo_pkg::DIST_K;
      end
      ddo_pkg::MS_X: begin
        mul_a = {{17{dist_r[47]}}, dist_r};
        mul_b = {c_r[33], c_r};
      end
      ddo_pkg::MS_Y: begin
        mul_a = {{17{dist_r[47]}}, dist_r};
        mul_b = {s_r[33], s_r};
      end
      ddo_pkg::MS_HD: begin
        mul_a = {{33{turn_r[31]}}, turn_r};
        mul_b = {3'b0, dt_r};
      end
      ddo_pkg::MS_HK: begin
        mul_a = {prod_r[63], prod_r};
        mul_b = ddo_pkg::HEAD_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [67:0] pp_lo, pp_hi;
  assign pp_lo = $signed({1'b0, mul_a[31:0]}) * mul_b;
  assign pp_hi = $signed(mul_a[64:32]) * mul_b;

  // post-processing of the product register
  logic signed [63:0] wh_sh, tr_sh;
  logic signed [99:0] dsh, psh;
  logic signed [49:0] nx_sum, ny_sum;
  assign wh_sh  = ($signed(acc_r[63:0]) + 64'sd128) >>> 8;
  assign tr_sh  = ($signed(acc_r[63:0]) + 64'sd32768) >>> 16;
  assign dsh    = acc_r >>> 50;
  assign psh    = acc_r >>> 30;
  assign nx_sum = {{2{acc_x_r[47]}}, acc_x_r} + psh[49:0];
  assign ny_sum = {{2{acc_y_r[47]}}, acc_y_r} + psh[49:0];

  // CORDIC
  logic [31:0] c_src, c_tst, c_ang;
  logic        c_flip;
  logic signed [33:0] xsh, ysh, atv;
  assign c_src  = cmd.chalf ? {1'b0, acc_h_r[31:1]} : acc_h_r;
  assign c_tst  = c_src + 32'h4000_0000;
  assign c_flip = c_tst[31];
  assign c_ang  = c_flip ? c_src + 32'h8000_0000 : c_src;
  assign xsh    = cx_r >>> cmd.step;
  assign ysh    = cy_r >>> cmd.step;
  assign atv    = {4'b0, ddo_pkg::atan_bam(5'(cmd.step))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= 16'd373;
      gain_r      <= 16'd458;
      wdb_r       <= 16'd1311;
      itw_r       <= 24'd242726;
      tdb_r       <= 20'd9830;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ddo_pkg::REG_SPEED_OFFSET:  off_r  <= cfg_wdata[15:0];
          ddo_pkg::REG_VELOCITY_GAIN: gain_r <= cfg_wdata[15:0];
          ddo_pkg::REG_WHEEL_DB:      wdb_r  <= cfg_wdata[15:0];
          ddo_pkg::REG_INV_TRACK:     itw_r  <= cfg_wdata;
          ddo_pkg::REG_TURN_DB:       tdb_r  <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      if (cmd.op == ddo_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall)            out_valid_r <= 1'b0;
      case (cmd.op)
        ddo_pkg::OP_POS_X: acc_x_r <= sat48(nx_sum);
        ddo_pkg::OP_POS_Y: acc_y_r <= sat48(ny_sum);
        ddo_pkg::OP_HEAD: begin
          acc_h_r <= acc_h_r + acc_r[71:40];
          prev_r  <= in_r.stamp_us;
          seen_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ddo_pkg::OP_LOAD:    in_r <= in_data;
      ddo_pkg::OP_MUL_LO:  acc_r <= {{32{pp_lo[67]}}, pp_lo};
      ddo_pkg::OP_MUL_HI:  acc_r <= acc_r + {pp_hi, 32'b0};
      ddo_pkg::OP_WHEEL_R: vr_r <= dband(sat32(wh_sh), {4'b0, wdb_r});
      ddo_pkg::OP_WHEEL_L: vl_r <= dband(sat32(wh_sh), {4'b0, wdb_r});
      ddo_pkg::OP_SUMS: begin
        fwd_r <= 32'(({vl_r[31], vl_r} + {vr_r[31], vr_r}) >>> 1);
        dif_r <= {vl_r[31], vl_r} - {vr_r[31], vr_r};
        dt_r  <= seen_r ? in_r.stamp_us - prev_r : 32'd0;
      end
      ddo_pkg::OP_TURN: turn_r <= dband(sat32(tr_sh), tdb_r);
      ddo_pkg::OP_PROD: prod_r <= acc_r[63:0];
      ddo_pkg::OP_DIST: dist_r <= dsh[47:0];
      ddo_pkg::OP_CORDIC_INIT: begin
        cx_r   <= ddo_pkg::CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= {{2{c_ang[31]}}, c_ang};
        flip_r <= c_flip;
      end
      ddo_pkg::OP_CORDIC_STEP: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ysh;
          cy_r <= cy_r + xsh;
          cz_r <= cz_r - atv;
        end else begin
          cx_r <= cx_r + ysh;
          cy_r <= cy_r - xsh;
          cz_r <= cz_r + atv;
        end
      end
      ddo_pkg::OP_CORDIC_FIN: begin
        c_r <= flip_r ? -cx_r : cx_r;
        s_r <= flip_r ? -cy_r : cy_r;
      end
      ddo_pkg::OP_EMIT: begin
        out_r.pos_x        <= acc_x_r;
        out_r.pos_y        <= acc_y_r;
        out_r.heading      <= acc_h_r;
        out_r.quat_z       <= q15(s_r);
        out_r.quat_w       <= q15(c_r);
        out_r.forward_rate <= fwd_r;
        out_r.turn_rate    <= turn_r;
      end
      default: ;
    endcase
  end

  assign out_data        = out_r;
  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

FILE: rtl/ddo_checker.sv
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on assert_macros.svh and ddo_pkg.
`include "assert_macros.svh"

module ddo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ddo_pkg::out_word_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "result changed")
  `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "took two words")

endmodule

bind diff_drive_odometry_integrator_core ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb_diff_drive_odometry_integrator_core.sv
// Testbench for diff_drive_odometry_integrator_core: drives motor reports and
// register writes, predicts each pose word and compares it on the result side.
// Depends on ddo_pkg and the core RTL.
module tb_diff_drive_odometry_integrator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTEPS = ddo_pkg::CORDIC_STEPS;
  localparam logic signed [63:0] POS_HI = 64'sd140737488355327;
  localparam logic signed [63:0] POS_LO = -64'sd140737488355328;
  localparam int LATENCY = 34 + 2 * NSTEPS;
  localparam int WATCHDOG_LIMIT = 200000;

  // ---------------------------------------------------------------------
  // Odometry predictor: own copy of the tuning registers and pose state.
  // ---------------------------------------------------------------------
  class odom_scoreboard;
    logic [15:0] offset_q, gain_q, wheel_db_q;
    logic [23:0] inv_track_q;
    logic [19:0] turn_db_q;
    logic signed [63:0] x_acc, y_acc;
    logic [31:0] yaw_acc, last_stamp;
    bit have_stamp;
    ddo_pkg::out_word_t pending[$];
    int mismatches;

    function void reset_state();
      offset_q = 16'd373; gain_q = 16'd458; wheel_db_q = 16'd1311;
      inv_track_q = 24'd242726; turn_db_q = 20'd9830;
      x_acc = 0; y_acc = 0; yaw_acc = 0; last_stamp = 0; have_stamp = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        ddo_pkg::REG_SPEED_OFFSET:  offset_q = val[15:0];
        ddo_pkg::REG_VELOCITY_GAIN: gain_q = val[15:0];
        ddo_pkg::REG_WHEEL_DB:      wheel_db_q = val[15:0];
        ddo_pkg::REG_INV_TRACK:     inv_track_q = val;
        ddo_pkg::REG_TURN_DB:       turn_db_q = val[19:0];
        default: ;
      endcase
    endfunction

    // saturate a 128-bit signed value to the 32-bit range
    function automatic logic signed [63:0] sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return v[63:0];
    endfunction

    function automatic logic signed [63:0] wheel_vel(logic signed [15:0] spd);
      logic signed [127:0] m;
      logic signed [63:0] v;
      m = 128'(spd) * 256;
      m = (spd > 0) ? m + $signed({112'd0, offset_q}) : m - $signed({112'd0, offset_q});
      v = sat32((m * $signed({112'd0, gain_q}) + 128) >>> 8);
      if ((v < 0 ? -v : v) < $signed({48'd0, wheel_db_q})) v = 0;
      return v;
    endfunction

    // cos/sin of binary angle, Q2.30
    function automatic void rotate(logic [31:0] ang, output logic signed [63:0] c,
                                   output logic signed [63:0] s);
      logic signed [63:0] x, y, z, nx;
      bit flip;
      x = 64'(ddo_pkg::CORDIC_GAIN); y = 0; flip = 0;
      if (32'(ang + 32'h40000000) >= 32'h80000000) begin
        ang = ang + 32'h80000000;
        flip = 1;
      end
      z = 64'($signed(ang));
      for (int i = 0; i < NSTEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - 64'(ddo_pkg::atan_bam(5'(i)));
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + 64'(ddo_pkg::atan_bam(5'(i)));
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function automatic logic signed [15:0] to_q15(logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function automatic logic signed [63:0] sat_pos(logic signed [63:0] v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
    endfunction

    function void note_report(ddo_pkg::in_word_t w);
      logic signed [63:0] vr, vl, fwd, turn, dt, travel, c, s, qc, qs;
      logic signed [127:0] p;
      ddo_pkg::out_word_t e;
      vr = wheel_vel(w.right_speed);
      vl = wheel_vel(w.left_speed);
      fwd = (vl + vr) >>> 1;
      turn = sat32(((128'(vl - vr) * $signed({104'd0, inv_track_q})) + 32768) >>> 16);
      if ((turn < 0 ? -turn : turn) < $signed({44'd0, turn_db_q})) turn = 0;
      dt = have_stamp ? $signed({32'd0, 32'(w.stamp_us - last_stamp)}) : 0;
      rotate(yaw_acc, c, s);
      p = (128'(fwd * dt) * $signed(128'(ddo_pkg::DIST_K))) >>> 50;
      travel = p[63:0];
      p = (128'(travel) * 128'(c)) >>> 30;
      x_acc = sat_pos(x_acc + p[63:0]);
      p = (128'(travel) * 128'(s)) >>> 30;
      y_acc = sat_pos(y_acc + p[63:0]);
      p = (128'(turn * dt) * $signed(128'(ddo_pkg::HEAD_K))) >>> 40;
      yaw_acc = yaw_acc + p[31:0];
      last_stamp = w.stamp_us;
      have_stamp = 1;
      rotate(yaw_acc >> 1, qc, qs);
      e.pos_x = x_acc[47:0]; e.pos_y = y_acc[47:0]; e.heading = yaw_acc;
      e.quat_z = to_q15(qs); e.quat_w = to_q15(qc);
      e.forward_rate = fwd[31:0]; e.turn_rate = turn[31:0];
      pending.push_back(e);
    endfunction

    function void check_pose(ddo_pkg::out_word_t got);
      ddo_pkg::out_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: x %h/%h y %h/%h hd %h/%h qz %h/%h qw %h/%h fw %h/%h tr %h/%h",
                   e.pos_x, got.pos_x, e.pos_y, got.pos_y, e.heading, got.heading,
                   e.quat_z, got.quat_z, e.quat_w, got.quat_w,
                   e.forward_rate, got.forward_rate, e.turn_rate, got.turn_rate);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [23:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  ddo_pkg::in_word_t in_data;
  ddo_pkg::out_word_t out_data;

  odom_scoreboard sb;
  int send_idle_pct, recv_idle_pct;  // idling odds, percent
  bit hold_off;                      // long receiver stall request
  int quiet_cycles;
  logic [31:0] clock_us;             // running stamp for well-formed streams

  diff_drive_odometry_integrator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor and watchdog on accepted words
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pose(out_data);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one report word; returns once the core takes it
  // (one edge first so valid is never driven twice in one step)
  task automatic send_report(ddo_pkg::in_word_t w);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_report(w);
    in_valid <= 0;
  endtask

  task automatic send_speeds(logic signed [15:0] r, logic signed [15:0] l, logic [31:0] st);
    ddo_pkg::in_word_t w;
    w.right_speed = r; w.left_speed = l; w.stamp_us = st;
    send_report(w);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one write, with cfg_we dropped again before the next write
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random report: mostly plausible speeds with forward-running stamps
  task automatic random_report();
    logic signed [15:0] r, l;
    logic [31:0] st;
    case ($urandom_range(9))
      0: begin r = 16'($urandom); l = 16'($urandom); end
      1: begin
        r = $signed(16'($urandom_range(3))) - 16'sd2;
        l = $signed(16'($urandom_range(3))) - 16'sd2;
      end
      default: begin
        r = $signed(16'($urandom_range(4000))) - 16'sd2000;
        l = r + $signed(16'($urandom_range(800))) - 16'sd400;
      end
    endcase
    if ($urandom_range(19) == 0) st = $urandom;
    else st = clock_us + $urandom_range(200000);
    clock_us = st;
    send_speeds(r, l, st);
  endtask

  task automatic random_settings();
    write_reg(ddo_pkg::REG_SPEED_OFFSET, 24'($urandom_range(1000)));
    write_reg(ddo_pkg::REG_VELOCITY_GAIN, 24'($urandom_range(2000)));
    write_reg(ddo_pkg::REG_WHEEL_DB, 24'($urandom_range(3000)));
    write_reg(ddo_pkg::REG_INV_TRACK, 24'($urandom_range(600000)));
    write_reg(ddo_pkg::REG_TURN_DB, 24'($urandom_range(30000)));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    in_valid = 0; in_data = '0;
    hold_off = 0; quiet_cycles = 0; clock_us = 0;
    send_idle_pct = 15; recv_idle_pct = 48;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: first report sees zero dt, field extremes, stamp wrap
    send_speeds(16'sd1000, 16'sd1000, 32'd123456);
    send_speeds(16'sd0, 16'sd0, 32'd223456);
    send_speeds(16'sd32767, 16'sd32767, 32'd243456);
    send_speeds(-16'sd32768, -16'sd32768, 32'd263456);
    send_speeds(16'sd32767, -16'sd32768, 32'd283456);
    send_speeds(-16'sd32768, 16'sd32767, 32'hFFFF_FFFF);
    send_speeds(16'sd1, -16'sd1, 32'd5000);        // stamp wrapped
    send_speeds(16'sd500, 16'sd2000, 32'd1000);    // stamp backwards
    send_speeds(-16'sd1500, 16'sd1500, 32'h8000_0000);
    send_speeds(16'sd1500, -16'sd1500, 32'hFFFF_0000);
    drain();

    // register extremes: zero offset/gain/deadbands, then maximum values
    write_reg(ddo_pkg::REG_SPEED_OFFSET, 24'd0);
    write_reg(ddo_pkg::REG_VELOCITY_GAIN, 24'd0);
    write_reg(ddo_pkg::REG_WHEEL_DB, 24'd0);
    write_reg(ddo_pkg::REG_INV_TRACK, 24'd0);
    write_reg(ddo_pkg::REG_TURN_DB, 24'd0);
    write_reg(3'd7, 24'hFFFFFF);                   // unknown index dropped
    send_speeds(16'sd100, -16'sd100, 32'h0001_0000);
    drain();
    write_reg(ddo_pkg::REG_VELOCITY_GAIN, 24'hFFFF);
    send_speeds(-16'sd1, 16'sd1, 32'h0002_0000);
    drain();
    write_reg(ddo_pkg::REG_SPEED_OFFSET, 24'hFFFFFF);       // upper bits masked
    write_reg(ddo_pkg::REG_WHEEL_DB, 24'hFFFF);
    write_reg(ddo_pkg::REG_INV_TRACK, 24'hFFFFFF);
    write_reg(ddo_pkg::REG_TURN_DB, 24'hFFFFFF);
    send_speeds(16'sd32767, -16'sd32768, 32'hF000_0000);
    send_speeds(-16'sd32768, 16'sd32767, 32'h7000_0000);
    drain();
    write_reg(ddo_pkg::REG_WHEEL_DB, 24'd0);
    write_reg(ddo_pkg::REG_TURN_DB, 24'd0);
    send_speeds(16'sd32767, -16'sd32768, 32'hF000_0000);  // rate saturation
    send_speeds(-16'sd32768, 16'sd32767, 32'h7000_0000);
    send_speeds(16'sd32767, 16'sd32767, 32'hF000_0000);   // drive toward position limit
    send_speeds(16'sd32767, 16'sd32767, 32'h7000_0000);
    drain();
    clock_us = 32'h7000_0000;

    // random phases under three idling profiles; random settings each phase, defaults in the last
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 48; recv_idle_pct = 15; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (ph == 8) begin
        write_reg(ddo_pkg::REG_SPEED_OFFSET, 24'd373);
        write_reg(ddo_pkg::REG_VELOCITY_GAIN, 24'd458);
        write_reg(ddo_pkg::REG_WHEEL_DB, 24'd1311);
        write_reg(ddo_pkg::REG_INV_TRACK, 24'd242726);
        write_reg(ddo_pkg::REG_TURN_DB, 24'd9830);
      end else begin
        random_settings();
      end
      if (ph == 4) begin
        // long receiver hold-off while reports keep coming
        fork
          begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
          repeat (6) random_report();
        join
      end
      for (int k = 0; k < 120; k++) random_report();
      drain();  // sender pauses until everything has come back
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_dp.sv
rtl/diff_drive_odometry_integrator_core.sv
rtl/ddo_checker.sv
tb/tb_diff_drive_odometry_integrator_core.sv
